// File: design/sha_pkg.sv
package sha_pkg;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_byte;
        logic pad_mark;
        logic pad_zero;
        logic pad_len;
        logic start_round;
        logic do_round;
        logic add_hash;
        logic reset_hash;
        logic clear_len;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic block_full;
        logic at_length;
        logic round_last;
    } t_status;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned LengthAt   = 56;
    localparam logic [7:0]  PadByte    = 8'h80;

    localparam logic [31:0] InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// File: design/sha256_stream_hasher_top.sv
// SHA-256 stream hasher.
// Slave channel: one item per message byte; tdata carries the byte, tuser
// bit 0 says whether the byte is present, tlast ends the message.
// Master channel: after end of message the eight digest words come out,
// word 0 first, tlast on the eighth.
// An item that does not fill a block and does not end the message leaves the
// controller idle, so such items can follow back to back.
// The item that fills the 64th byte of a block starts a compression, which
// runs one round per cycle on a single round unit and then adds into the
// hash words.
// End of message writes the 0x80 marker, the zero bytes and the eight length
// bytes one per cycle while no compression runs, with a step that writes
// nothing on reaching the length position, and runs one or two compressions.
// An end item whose own byte fills a block first runs that compression before
// the padding. The first digest word is offered once the last compression has
// added into the hash words. Each word waits for m_axis_tready, and no item is
// taken until the last word has gone, after which the hash returns to its
// initial value. Reset (synchronous, active low) restores the initial hash,
// clears the byte count and length and returns the controller to idle.
module sha256_stream_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic        s_axis_tuser,   // byte_present
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word[31:0]
    output logic        m_axis_tlast    // last_word
);

    sha_pkg::t_cmd    w_cmd;
    sha_pkg::t_status w_status;
    logic [2:0]       w_word_sel;

    sha_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_byte_present(s_axis_tuser),
        .i_end         (s_axis_tlast),
        .i_out_ready   (m_axis_tready),
        .i_status      (w_status),
        .o_in_ready    (s_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_last    (m_axis_tlast),
        .o_word_sel    (w_word_sel),
        .o_cmd         (w_cmd)
    );

    sha_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_byte     (s_axis_tdata),
        .i_word_sel (w_word_sel),
        .o_status   (w_status),
        .o_hash_word(m_axis_tdata)
    );

endmodule

// File: design/sha_datapath.sv
module sha_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha_pkg::t_cmd      i_cmd,
    input  logic [7:0]         i_byte,
    input  logic [2:0]         i_word_sel,
    output sha_pkg::t_status   o_status,
    output logic [31:0]        o_hash_word
);

    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_len, n_len;
    logic [31:0] r_hash [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [5:0]  r_rnd;
    logic [7:0]  w_byte;
    logic [2:0]  w_len_idx;
    logic        w_pad_any;
    logic [31:0] w_t1, w_t2, w_new_w, w_wt, w_s0, w_s1;

    assign w_pad_any = i_cmd.pad_mark | i_cmd.pad_zero | i_cmd.pad_len;
    assign w_len_idx = 3'd7 - r_fill[2:0];

    // Byte written: message byte, pad marker, zero or a big-endian length byte.
    always_comb begin
        priority if (i_cmd.pad_mark) begin
            w_byte = sha_pkg::PadByte;
        end else if (i_cmd.pad_zero) begin
            w_byte = 8'h00;
        end else if (i_cmd.pad_len) begin
            w_byte = r_len[{w_len_idx, 3'b000} +: 8];
        end else begin
            w_byte = i_byte;
        end
    end

    // Fill count and bit length; padding bytes do not count towards the length.
    always_comb begin
        n_fill = r_fill;
        n_len  = r_len;
        if (i_cmd.load_byte) begin
            n_fill = r_fill + 6'd1;
            if (!w_pad_any) begin
                n_len = r_len + 64'd8;
            end
        end
        if (i_cmd.clear_len) begin
            n_len  = '0;
            n_fill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_len  <= '0;
        end else begin
            r_fill <= n_fill;
            r_len  <= n_len;
        end
    end

    // Message schedule over a 16-word window.
    always_comb begin
        w_s0    = sha_pkg::rotr(r_w[1], 7) ^ sha_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        w_s1    = sha_pkg::rotr(r_w[14], 17) ^ sha_pkg::rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new_w = r_w[0] + w_s0 + r_w[9] + w_s1;
        w_wt    = r_w[0];
    end

    // One compression round.
    always_comb begin
        w_t1 = r_v[7] + (sha_pkg::rotr(r_v[4], 6) ^ sha_pkg::rotr(r_v[4], 11) ^
               sha_pkg::rotr(r_v[4], 25)) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) +
               sha_pkg::RoundK[r_rnd] + w_wt;
        w_t2 = (sha_pkg::rotr(r_v[0], 2) ^ sha_pkg::rotr(r_v[0], 13) ^
               sha_pkg::rotr(r_v[0], 22)) +
               ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // Block window: bytes shift in at the bottom, so after 64 bytes the first
    // byte sits in the top of word 0. During rounds it acts as the schedule.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= {r_w[i][23:0], r_w[i + 1][31:24]};
            end
            r_w[15] <= {r_w[15][23:0], w_byte};
        end else if (i_cmd.do_round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= w_new_w;
        end
    end

    // Working variables and round counter.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_round) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_hash[i];
            end
            r_rnd <= '0;
        end else if (i_cmd.do_round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
            r_rnd  <= r_rnd + 6'd1;
        end
    end

    // Hash words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reset_hash) begin
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= sha_pkg::InitHash[i];
            end
        end else if (i_cmd.add_hash) begin
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= r_hash[i] + r_v[i];
            end
        end
    end

    // The next byte written completes the block when the count stands at 63.
    assign o_status.block_full = (r_fill == 6'd63);
    assign o_status.at_length  = (r_fill == 6'(sha_pkg::LengthAt));
    assign o_status.round_last = (r_rnd == 6'd63);
    assign o_hash_word         = r_hash[i_word_sel];

endmodule

// File: design/sha_ctrl.sv
module sha_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_byte_present,
    input  logic              i_end,
    input  logic              i_out_ready,
    input  sha_pkg::t_status  i_status,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output logic              o_out_last,
    output logic [2:0]        o_word_sel,
    output sha_pkg::t_cmd     o_cmd
);

    sha_pkg::t_state r_state, n_state;
    sha_pkg::t_state r_resume, n_resume;
    logic [2:0]      r_word, n_word;
    logic            w_acc;

    assign w_acc = i_in_valid && (r_state == sha_pkg::ST_IDLE);

    // Next state; r_resume holds where to continue after a compression.
    always_comb begin
        n_state  = r_state;
        n_resume = r_resume;
        n_word   = r_word;
        unique case (r_state)
            sha_pkg::ST_IDLE: begin
                if (w_acc) begin
                    if (i_byte_present && i_status.block_full) begin
                        n_state  = sha_pkg::ST_ROUND;
                        n_resume = i_end ? sha_pkg::ST_PAD_MARK : sha_pkg::ST_IDLE;
                    end else if (i_end) begin
                        n_state = sha_pkg::ST_PAD_MARK;
                    end
                end
            end
            sha_pkg::ST_ROUND: begin
                if (i_status.round_last) begin
                    n_state = sha_pkg::ST_FINAL;
                end
            end
            sha_pkg::ST_FINAL: begin
                n_state = r_resume;
            end
            sha_pkg::ST_PAD_MARK: begin
                if (i_status.block_full) begin
                    n_state  = sha_pkg::ST_ROUND;
                    n_resume = sha_pkg::ST_PAD_ZERO;
                end else begin
                    n_state = sha_pkg::ST_PAD_ZERO;
                end
            end
            sha_pkg::ST_PAD_ZERO: begin
                if (i_status.at_length) begin
                    n_state = sha_pkg::ST_PAD_LEN;
                end else if (i_status.block_full) begin
                    n_state  = sha_pkg::ST_ROUND;
                    n_resume = sha_pkg::ST_PAD_ZERO;
                end
            end
            sha_pkg::ST_PAD_LEN: begin
                if (i_status.block_full) begin
                    n_state  = sha_pkg::ST_ROUND;
                    n_resume = sha_pkg::ST_EMIT;
                end
            end
            sha_pkg::ST_EMIT: begin
                if (i_out_ready) begin
                    n_word = r_word + 3'd1;
                    if (r_word == 3'd7) begin
                        n_state = sha_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = sha_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sha_pkg::ST_IDLE;
            r_resume <= sha_pkg::ST_IDLE;
            r_word   <= '0;
        end else begin
            r_state  <= n_state;
            r_resume <= n_resume;
            r_word   <= n_word;
        end
    end

    // Outputs and commands.
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_out_last  = 1'b0;
        o_word_sel  = r_word;
        unique case (r_state)
            sha_pkg::ST_IDLE: begin
                o_in_ready        = 1'b1;
                o_cmd.load_byte   = w_acc && i_byte_present;
                o_cmd.start_round = w_acc && i_byte_present && i_status.block_full;
            end
            sha_pkg::ST_ROUND: begin
                o_cmd.do_round = 1'b1;
            end
            sha_pkg::ST_FINAL: begin
                o_cmd.add_hash = 1'b1;
            end
            sha_pkg::ST_PAD_MARK: begin
                o_cmd.load_byte   = 1'b1;
                o_cmd.pad_mark    = 1'b1;
                o_cmd.start_round = i_status.block_full;
            end
            sha_pkg::ST_PAD_ZERO: begin
                o_cmd.load_byte   = !i_status.at_length;
                o_cmd.pad_zero    = 1'b1;
                o_cmd.start_round = i_status.block_full;
            end
            sha_pkg::ST_PAD_LEN: begin
                o_cmd.load_byte   = 1'b1;
                o_cmd.pad_len     = 1'b1;
                o_cmd.start_round = i_status.block_full;
            end
            sha_pkg::ST_EMIT: begin
                o_out_valid = 1'b1;
                o_out_last  = (r_word == 3'd7);
                if (i_out_ready && r_word == 3'd7) begin
                    o_cmd.reset_hash = 1'b1;
                    o_cmd.clear_len  = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule
